// ===== rtl/core/plm_pkg.sv =====
`default_nettype none
package plm_pkg;

  // Widths of the request and result fields.
  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int FPOS_W   = 7;
  localparam int COUNT_W  = 7;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_BITS  = MODE_W + VALUE_W + POS_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STATUS_W + 1 + FPOS_W + COUNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIND
  } state_t;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_LOAD
  } cell_sel_t;

  typedef struct packed {
    cell_sel_t sel;
    logic      capture;
    logic      cmp_en;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/positional_list_engine.sv =====
`default_nettype none
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit
// values addressed by 1-based positions, held in a row of cells.
// Requests arrive on the s_axis channel: tdata carries mode in bits [1:0]
// (0 insert, 1 delete, 2 search), item_value in [33:2] and position in
// [41:34]. Every request yields exactly one result on m_axis, whose tdata
// carries status, found, found_position and entry_count from bit 0 up.
// A request passes two steps after acceptance: in the run step, the cells
// from the target position on shift toward the tail (insert) or pull from
// the tail side (delete), or the occupied cells compare their entry against
// the key (search), all at once; in the find step, the lowest matching cell
// is encoded and the result is written to the output register. A new request
// is accepted in the cycle the result is loaded, so requests do not overlap;
// the request rate is set by the compare stage and the find-first encoder.
// The output register holds its result until the receiver takes it; while it
// is full and not taken, the block waits in its encode step and does not
// accept further requests, so nothing is lost or repeated.
// Synchronous reset empties the list and drops any pending result; in the
// idle state no request is taken while it is held. Cell contents are not
// cleared, since only entries below the count are ever used.
module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // mode [1:0], item_value [33:2], position [41:34], zero pad above.
  input  wire logic [plm_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // status [1:0], found [2], found_position [9:3], entry_count [16:10].
  output logic      [plm_pkg::OUT_W-1:0]   m_axis_tdata
);
  import plm_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  // Wide enough to compare positions, counts and cell indexes without wrap.
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  state_t state, state_next;

  // The request being worked on.
  logic [MODE_W-1:0]  req_mode;
  logic [VALUE_W-1:0] req_value;
  logic [POS_W-1:0]   req_pos;

  logic [CNT_W-1:0]   length;
  status_t            req_status;

  logic               s_accept;
  logic               out_load;
  logic               run_step;

  // Output register fields.
  logic [STATUS_W-1:0] out_status;
  logic                out_found;
  logic [FPOS_W-1:0]   out_fpos;
  logic [COUNT_W-1:0]  out_count;

  assign s_accept = s_axis_tvalid && s_axis_tready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        state_next = S_FIND;
      end
      S_FIND: begin
        if (out_load) begin
          state_next = s_accept ? S_RUN : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    out_load      = 1'b0;
    run_step      = 1'b0;
    s_axis_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = !rst;
      end
      S_RUN: begin
        run_step = 1'b1;
      end
      S_FIND: begin
        out_load      = !m_axis_tvalid || m_axis_tready;
        s_axis_tready = out_load;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      req_mode  <= s_axis_tdata[MODE_W-1:0];
      req_value <= s_axis_tdata[MODE_W +: VALUE_W];
      req_pos   <= s_axis_tdata[MODE_W + VALUE_W +: POS_W];
    end
  end

  // Range checks and list-edit decision for the request in flight.
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] len_x;
  logic [CMP_W-1:0] slot_k;
  status_t          status_now;
  logic             do_insert;
  logic             do_delete;
  logic             do_search;

  assign pos_x  = CMP_W'(req_pos);
  assign len_x  = CMP_W'(length);
  assign slot_k = pos_x - CMP_W'(1);

  always_comb begin
    status_now = STAT_RANGE;
    do_insert  = 1'b0;
    do_delete  = 1'b0;
    do_search  = 1'b0;
    case (req_mode)
      MODE_INSERT: begin
        if (pos_x == '0 || pos_x > len_x + CMP_W'(1)) begin
          status_now = STAT_RANGE;
        end else if (len_x >= CMP_W'(CAPACITY)) begin
          status_now = STAT_FULL;
        end else begin
          status_now = STAT_DONE;
          do_insert  = 1'b1;
        end
      end
      MODE_DELETE: begin
        if (len_x == '0 || pos_x == '0 || pos_x > len_x) begin
          status_now = STAT_RANGE;
        end else begin
          status_now = STAT_DONE;
          do_delete  = 1'b1;
        end
      end
      MODE_SEARCH: begin
        status_now = STAT_DONE;
        do_search  = 1'b1;
      end
      default: begin
        status_now = STAT_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (run_step) begin
      if (do_insert) begin
        length <= length + CNT_W'(1);
      end else if (do_delete) begin
        length <= length - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_step) begin
      req_status <= status_now;
    end
  end

  // The row of cells.
  logic [VALUE_W-1:0]  entries [CAPACITY];
  logic [CAPACITY-1:0] hits;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t          ctl;
    logic [VALUE_W-1:0] left_value;
    logic [VALUE_W-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_value = req_value;
    end else begin : g_mid_l
      assign left_value = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = entries[i];
    end else begin : g_mid_r
      assign right_value = entries[i+1];
    end

    always_comb begin
      ctl.sel     = SEL_HOLD;
      ctl.capture = run_step;
      ctl.cmp_en  = do_search && (CMP_W'(i) < len_x);
      if (run_step && do_insert) begin
        if (CMP_W'(i) == slot_k) begin
          ctl.sel = SEL_LOAD;
        end else if (CMP_W'(i) > slot_k) begin
          ctl.sel = SEL_LEFT;
        end
      end else if (run_step && do_delete) begin
        if (CMP_W'(i) >= slot_k) begin
          ctl.sel = SEL_RIGHT;
        end
      end
    end

    plm_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .left_value  (left_value),
      .right_value (right_value),
      .key         (req_value),
      .entry       (entries[i]),
      .match       (hits[i])
    );
  end

  // Lowest matching cell gives the search answer.
  logic             any_hit;
  logic [IDX_W-1:0] first_idx;
  logic [CNT_W-1:0] first_pos;

  plm_first #(
    .N     (CAPACITY),
    .IDX_W (IDX_W)
  ) u_first (
    .hits      (hits),
    .any_hit   (any_hit),
    .first_idx (first_idx)
  );

  assign first_pos = CNT_W'(first_idx) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= req_status;
      out_found  <= any_hit;
      out_fpos   <= any_hit ? FPOS_W'(first_pos) : '0;
      out_count  <= COUNT_W'(length);
    end
  end

  assign m_axis_tdata = OUT_W'({out_count, out_fpos, out_found, out_status});

endmodule
`default_nettype wire

// ===== rtl/core/plm_cell.sv =====
`default_nettype none
module plm_cell (
  input  wire logic                         clk,
  input  wire plm_pkg::cell_ctl_t           ctl,
  input  wire logic [plm_pkg::VALUE_W-1:0]  left_value,
  input  wire logic [plm_pkg::VALUE_W-1:0]  right_value,
  input  wire logic [plm_pkg::VALUE_W-1:0]  key,
  output logic      [plm_pkg::VALUE_W-1:0]  entry,
  output logic                              match
);
  import plm_pkg::*;

  // One list slot. Inserts shift entries toward the tail through the left
  // neighbor, deletes pull them toward the head from the right neighbor.
  always_ff @(posedge clk) begin
    case (ctl.sel)
      SEL_LEFT:  entry <= left_value;
      SEL_RIGHT: entry <= right_value;
      SEL_LOAD:  entry <= key;
      default:   entry <= entry;
    endcase
    if (ctl.capture) begin
      match <= ctl.cmp_en && (entry == key);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/plm_first.sv =====
`default_nettype none
module plm_first #(
  parameter int N     = 64,
  parameter int IDX_W = 6
) (
  input  wire logic [N-1:0]     hits,
  output logic                  any_hit,
  output logic      [IDX_W-1:0] first_idx
);

  logic [N-1:0] lowest;

  // Isolate the lowest set bit, then encode the one-hot word bit by bit.
  assign lowest  = hits & (~hits + N'(1));
  assign any_hit = |hits;

  for (genvar b = 0; b < IDX_W; b++) begin : g_bit
    logic [N-1:0] bit_mask;
    always_comb begin
      for (int i = 0; i < N; i++) begin
        bit_mask[i] = 1'((i >> b) & 1);
      end
    end
    assign first_idx[b] = |(lowest & bit_mask);
  end

endmodule
`default_nettype wire

// ===== sim/positional_list_engine_tb.sv =====
`timescale 1ns / 1ps

module positional_list_engine_tb;
  import plm_pkg::*;

  localparam int CAP = 64;
  // Mode code that the package leaves unnamed; the block must reject it.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 930;

  typedef struct {
    status_t              status;
    logic                 found;
    logic [FPOS_W-1:0]    fpos;
    logic [COUNT_W-1:0]   depth;
  } list_result_t;

  // Shadow copy of the list plus the results still owed by the block.
  class list_mirror;
    int cap;
    logic [VALUE_W-1:0] entries[$];
    list_result_t owed[$];
    int errors;
    int checked;
    int search_hits;
    int full_rejects;

    function new(int c);
      cap = c;
    endfunction

    function int depth();
      return entries.size();
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its result.
    function void note_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                               logic [POS_W-1:0] pos);
      list_result_t r;
      int len;
      r.status = STAT_DONE;
      r.found = 1'b0;
      r.fpos = '0;
      len = entries.size();
      case (mode)
        MODE_INSERT: begin
          // The position is checked before the fill level.
          if (pos == 0 || pos > len + 1) begin
            r.status = STAT_RANGE;
          end else if (len >= cap) begin
            r.status = STAT_FULL;
            full_rejects++;
          end else begin
            entries.insert(pos - 1, value);
          end
        end
        MODE_DELETE: begin
          if (len == 0 || pos == 0 || pos > len) begin
            r.status = STAT_RANGE;
          end else begin
            entries.delete(pos - 1);
          end
        end
        MODE_SEARCH: begin
          for (int i = 0; i < len; i++) begin
            if (entries[i] == value) begin
              r.found = 1'b1;
              r.fpos = FPOS_W'(i + 1);
              search_hits++;
              break;
            end
          end
        end
        default: begin
          r.status = STAT_RANGE;
        end
      endcase
      r.depth = COUNT_W'(entries.size());
      owed.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      list_result_t r;
      if (owed.size() == 0) begin
        $display("%0t ns: result %h arrived with nothing expected", $time, data);
        errors++;
        return;
      end
      r = owed.pop_front();
      checked++;
      if (data[1:0] !== r.status) begin
        $display("%0t ns: status expected %0d, got %0d", $time, r.status, data[1:0]);
        errors++;
      end
      if (data[2] !== r.found) begin
        $display("%0t ns: found expected %0d, got %0d", $time, r.found, data[2]);
        errors++;
      end
      if (data[9:3] !== r.fpos) begin
        $display("%0t ns: found_position expected %0d, got %0d", $time, r.fpos, data[9:3]);
        errors++;
      end
      if (data[16:10] !== r.depth) begin
        $display("%0t ns: entry_count expected %0d, got %0d", $time, r.depth, data[16:10]);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // mode [1:0], item_value [33:2], position [41:34], zero pad above.
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // status [1:0], found [2], found_position [9:3], entry_count [16:10].
  logic [OUT_W-1:0] m_axis_tdata;

  list_mirror mirror = new(CAP);
  int mode_hits[4];
  int cycle_no;

  positional_list_engine #(
    .CAPACITY(CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                              logic [POS_W-1:0] pos);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_W - IN_BITS){1'b0}}, pos, value, mode};
    do @(posedge clk); while (!s_axis_tready);
    mirror.note_request(mode, value, pos);
    mode_hits[mode]++;
  endtask

  task automatic pause(int cycles);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Hold the sender off until every owed result has come back.
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  // Mix of wide random values, small values that repeat, the two extremes
  // and copies of values already held, so that searches hit often.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 8) - 4;
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: begin
        if (mirror.entries.size() == 0) return $urandom;
        return mirror.entries[$urandom_range(0, mirror.entries.size() - 1)];
      end
    endcase
  endfunction

  // Mostly legal positions up to hi, with zero, positions past the end and
  // fully random ones mixed in.
  function automatic logic [POS_W-1:0] pick_position(int hi);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7 && hi >= 1) return POS_W'($urandom_range(1, hi));
    if (roll == 7) return '0;
    if (roll == 8) return POS_W'($urandom_range(hi + 1, 255));
    return POS_W'($urandom_range(0, 255));
  endfunction

  // The receiver runs through four moods: always ready, mostly ready,
  // mostly stalled, and long stalls broken by short ready windows.
  always @(negedge clk) begin
    cycle_no <= cycle_no + 1;
    case ((cycle_no / 256) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ((cycle_no % 16) >= 10);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      mirror.check_result(m_axis_tdata);
    end
  end

  initial begin
    #1_000_000;
    $display("positional_list_engine_tb failed");
    $finish;
  end

  initial begin
    bit filling;
    int burst_left;
    int gap;
    int roll;
    logic [MODE_W-1:0] mode;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0] pos;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty list, the value extremes, every range rejection path,
    // head, middle and tail edits, duplicates and the unused mode.
    send_request(MODE_SEARCH, 32'h0, 8'd0);
    send_request(MODE_DELETE, 32'h0, 8'd1);
    send_request(MODE_INSERT, 32'h5, 8'd0);
    send_request(MODE_INSERT, 32'h5, 8'd2);
    send_request(MODE_INSERT, 32'h7fff_ffff, 8'd1);
    send_request(MODE_INSERT, 32'h8000_0000, 8'd2);
    send_request(MODE_INSERT, 32'h0, 8'd1);
    send_request(MODE_INSERT, 32'hffff_ffff, 8'd2);
    send_request(MODE_INSERT, 32'h1, 8'd255);
    send_request(MODE_INSERT, 32'h1, 8'd6);
    send_request(MODE_SEARCH, 32'h8000_0000, 8'd0);
    send_request(MODE_SEARCH, 32'h1234_5678, 8'd0);
    send_request(MODE_INSERT, 32'hffff_ffff, 8'd5);
    send_request(MODE_SEARCH, 32'hffff_ffff, 8'd0);
    send_request(MODE_UNUSED, 32'hffff_ffff, 8'd255);
    send_request(MODE_DELETE, 32'h0, 8'd0);
    send_request(MODE_DELETE, 32'h0, 8'd6);
    send_request(MODE_DELETE, 32'hffff_ffff, 8'd255);
    send_request(MODE_DELETE, 32'h0, 8'd1);
    send_request(MODE_DELETE, 32'h0, 8'd4);
    send_request(MODE_DELETE, 32'h5555_aaaa, 8'd2);
    send_request(MODE_SEARCH, 32'h7fff_ffff, 8'd255);
    send_request(MODE_SEARCH, 32'h8000_0000, 8'haa);
    drain_results();

    // Random part: the list is driven up to capacity and back down to empty
    // a few times, so that full and empty conditions both come up.
    filling = 1'b1;
    burst_left = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 150 == 149) drain_results();
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) pause(gap);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
      end
      burst_left--;

      if (filling && mirror.depth() == CAP && $urandom_range(0, 5) == 0) filling = 1'b0;
      if (!filling && mirror.depth() == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;

      roll = $urandom_range(0, 99);
      if (roll < (filling ? 60 : 15)) begin
        mode = MODE_INSERT;
        pos = pick_position(mirror.depth() + 1);
      end else if (roll < 75) begin
        mode = MODE_DELETE;
        pos = pick_position(mirror.depth());
      end else if (roll < 95) begin
        mode = MODE_SEARCH;
        pos = POS_W'($urandom_range(0, 255));
      end else begin
        mode = MODE_UNUSED;
        pos = POS_W'($urandom_range(0, 255));
      end
      value = pick_value();
      send_request(mode, value, pos);
    end

    drain_results();
    repeat (10) @(posedge clk);

    $display("Requests: %0d insert, %0d delete, %0d search, %0d unused mode; %0d results checked.",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mirror.checked);
    $display("Inserts refused on a full list: %0d; searches that matched: %0d.",
             mirror.full_rejects, mirror.search_hits);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("positional_list_engine_tb passed");
    end else begin
      $display("positional_list_engine_tb failed");
    end
    $finish;
  end

endmodule
